### src/jefs_pkg.sv
// shared types, constants and codes for the engine frame scheduler
package jefs_pkg;

	localparam int unsigned FRAME_GAP_MS = 50;
	localparam logic [12:0] GAP_WAIT = 13'(FRAME_GAP_MS);
	localparam logic [12:0] GAP_SPENT = 13'(2 * FRAME_GAP_MS);
	localparam logic [15:0] GAP_MAX = 16'hFFFF;

	localparam logic [28:0] ID_EEC1 = 29'h0CF00400;
	localparam logic [28:0] ID_ET1 = 29'h18FEEE00;
	localparam logic [28:0] ID_EFLP1 = 29'h18FEEF00;

	localparam logic [15:0] RAW16_MAX = 16'd64255;
	localparam logic [7:0] RAW8_MAX = 8'd250;
	localparam logic [15:0] RAW16_NA = 16'hFFFF;

	localparam logic [7:0] PF_TSC1 = 8'd0;
	localparam logic [7:0] PF_EEC1 = 8'd240;
	localparam logic [7:0] PS_EEC1 = 8'd4;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_RX = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		SLOT_EEC1 = 2'd0,
		SLOT_ET1 = 2'd1,
		SLOT_EFLP1 = 2'd2
	} slot_t;

	localparam logic KIND_TX = 1'b0;
	localparam logic KIND_CMD = 1'b1;

	localparam logic [3:0] REG_SIM_ENABLE = 4'd0;
	localparam logic [3:0] REG_CYCLE_PERIOD = 4'd1;
	localparam logic [3:0] REG_ENGINE_SPEED = 4'd2;
	localparam logic [3:0] REG_TORQUE = 4'd3;
	localparam logic [3:0] REG_COOLANT = 4'd4;
	localparam logic [3:0] REG_FUEL = 4'd5;
	localparam logic [3:0] REG_OIL_TEMP = 4'd6;
	localparam logic [3:0] REG_OIL_PRESSURE = 4'd7;

	typedef struct packed {
		logic [1:0] func;
		logic [28:0] rx_id;
		logic [63:0] rx_payload;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [28:0] tx_id;
		logic [63:0] tx_payload;
		logic [15:0] cmd_speed_raw;
		logic cmd_valid;
		logic [31:0] sent_total;
		logic [1:0] next_slot;
	} out_item_t;

	typedef struct packed {
		logic sim_enable;
		logic [12:0] cycle_period_ms;
		logic [15:0] speed_rpm8;
		logic signed [7:0] torque_percent;
		logic signed [8:0] clnt_degc;
		logic signed [8:0] fuel_degc;
		logic signed [13:0] oil_t32;
		logic [9:0] oil_kpa;
	} cfg_regs_t;

	typedef struct packed {
		logic hit;
		logic [15:0] speed;
	} rx_dec_t;

endpackage

### src/jefs_encode.sv
// builds identifier and payload of the frame in the given slot
module jefs_encode import jefs_pkg::*; (
	input cfg_regs_t regs,
	input logic [1:0] slot,
	output logic [28:0] tx_id,
	output logic [63:0] tx_payload
);

	logic signed [9:0] torque_sum;
	logic signed [10:0] coolant_sum;
	logic signed [10:0] fuel_sum;
	logic signed [16:0] oil_sum;
	logic [7:0] torque_b;
	logic [7:0] coolant_b;
	logic [7:0] fuel_b;
	logic [15:0] oil_w;
	logic [15:0] speed_w;
	logic [7:0] press_b;

	always_comb begin
		torque_sum = 10'(regs.torque_percent) + 10'sd125;
		coolant_sum = 11'(regs.clnt_degc) + 11'sd40;
		fuel_sum = 11'(regs.fuel_degc) + 11'sd40;
		oil_sum = 17'(regs.oil_t32) + 17'sd8736;

		if (torque_sum < 0)
			torque_b = 8'd0;
		else if (torque_sum > 10'sd250)
			torque_b = RAW8_MAX;
		else
			torque_b = torque_sum[7:0];

		if (coolant_sum < 0)
			coolant_b = 8'd0;
		else if (coolant_sum > 11'sd250)
			coolant_b = RAW8_MAX;
		else
			coolant_b = coolant_sum[7:0];

		if (fuel_sum < 0)
			fuel_b = 8'd0;
		else if (fuel_sum > 11'sd250)
			fuel_b = RAW8_MAX;
		else
			fuel_b = fuel_sum[7:0];

		if (oil_sum < 0)
			oil_w = 16'd0;
		else if (oil_sum > 17'sd64255)
			oil_w = RAW16_MAX;
		else
			oil_w = oil_sum[15:0];

		speed_w = (regs.speed_rpm8 > RAW16_MAX) ? RAW16_MAX : regs.speed_rpm8;
		press_b = (regs.oil_kpa[9:2] > RAW8_MAX) ? RAW8_MAX : regs.oil_kpa[9:2];

		case (slot)
			SLOT_EEC1: begin
				tx_id = ID_EEC1;
				tx_payload = {24'hFFFFFF, speed_w, torque_b, torque_b, 8'hFF};
			end
			SLOT_ET1: begin
				tx_id = ID_ET1;
				tx_payload = {32'hFFFFFFFF, oil_w, fuel_b, coolant_b};
			end
			default: begin
				tx_id = ID_EFLP1;
				tx_payload = {32'hFFFFFFFF, press_b, 24'hFFFFFF};
			end
		endcase
	end

endmodule

### src/jefs_rxdec.sv
// decodes a received frame into a speed command
module jefs_rxdec import jefs_pkg::*; (
	input logic [28:0] rx_id,
	input logic [63:0] rx_payload,
	output rx_dec_t dec
);

	logic [15:0] std_raw;

	always_comb begin
		std_raw = rx_payload[39:24];
		dec.hit = 1'b0;
		dec.speed = 16'd0;
		if (rx_id[23:16] == PF_TSC1) begin
			dec.hit = 1'b1;
			dec.speed = rx_payload[23:8];
		end else if (rx_id[23:16] == PF_EEC1 && rx_id[15:8] == PS_EEC1
				&& rx_id[7:0] != 8'd0) begin
			dec.hit = 1'b1;
			// fallback pair when the standard bytes read not available
			dec.speed = (std_raw != RAW16_NA) ? std_raw : rx_payload[47:32];
		end
	end

endmodule

### src/j1939_engine_frame_scheduler.sv
// engine frame scheduler top level: registers, state and flow control
//
// in channel (in_valid, in_ready, in_item) takes one item per cycle while
// no result is stalled: a 1 ms tick, a received CAN frame or a stats clear.
// out channel (out_valid, out_ready, out_item) gives a transmitted frame
// after a tick that ends a gap, or a speed command after a matching frame.
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the eight
// engine registers; cfg_ready is always high.
// an accepted item sits in the input register; its result is loaded into
// the output register when the item advances.
// throughput: one item per cycle unless a result stalls, set by the single
// pass of encode and decode logic between the input and output register.
// a stalled receiver holds the output register; the input register still
// drains items that give no result and takes a new item in the cycle the
// output is taken.
// reset clears the gap counter to its maximum, so the first enabled tick
// sends EEC1 at once; slot, counters and the command go to zero and the
// registers return to their defaults.
module j1939_engine_frame_scheduler import jefs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [3:0] cfg_index,
	input logic [15:0] cfg_data
);

	cfg_regs_t regs_q;
	logic s1_valid;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_item_q;

	logic [15:0] gap_q;
	logic [1:0] slot_q;
	logic [31:0] sent_q;
	logic [15:0] cmd_speed_q;
	logic cmd_seen_q;

	logic [28:0] enc_id;
	logic [63:0] enc_payload;
	rx_dec_t dec;

	logic [15:0] gap_inc;
	logic [12:0] wait_ms;
	logic send;
	logic has_result;
	logic advance;
	logic [1:0] slot_next;

	jefs_encode u_encode (
		.regs(regs_q),
		.slot(slot_q),
		.tx_id(enc_id),
		.tx_payload(enc_payload)
	);

	jefs_rxdec u_rxdec (
		.rx_id(item_s1.rx_id),
		.rx_payload(item_s1.rx_payload),
		.dec(dec)
	);

	always_comb begin
		gap_inc = (gap_q == GAP_MAX) ? gap_q : gap_q + 16'd1;
		if (slot_q == SLOT_EEC1 || slot_q == SLOT_ET1)
			wait_ms = GAP_WAIT;
		else
			wait_ms = (regs_q.cycle_period_ms > GAP_SPENT)
				? regs_q.cycle_period_ms - GAP_SPENT : GAP_WAIT;
		send = regs_q.sim_enable && (gap_inc >= {3'd0, wait_ms});
		case (slot_q)
			SLOT_EEC1: slot_next = SLOT_ET1;
			SLOT_ET1: slot_next = SLOT_EFLP1;
			default: slot_next = SLOT_EEC1;
		endcase
		case (item_s1.func)
			FUNC_TICK: has_result = send;
			FUNC_RX: has_result = dec.hit;
			default: has_result = 1'b0;
		endcase
		advance = s1_valid && (!has_result || !out_valid_q || out_ready);
	end

	assign in_ready = !s1_valid || advance;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sim_enable <= 1'b0;
			regs_q.cycle_period_ms <= 13'd500;
			regs_q.speed_rpm8 <= 16'd12000;
			regs_q.torque_percent <= 8'sd50;
			regs_q.clnt_degc <= 9'sd85;
			regs_q.fuel_degc <= 9'sd40;
			regs_q.oil_t32 <= 14'sd2880;
			regs_q.oil_kpa <= 10'd400;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SIM_ENABLE: regs_q.sim_enable <= cfg_data[0];
				REG_CYCLE_PERIOD: regs_q.cycle_period_ms <= cfg_data[12:0];
				REG_ENGINE_SPEED: regs_q.speed_rpm8 <= cfg_data;
				REG_TORQUE: regs_q.torque_percent <= cfg_data[7:0];
				REG_COOLANT: regs_q.clnt_degc <= cfg_data[8:0];
				REG_FUEL: regs_q.fuel_degc <= cfg_data[8:0];
				REG_OIL_TEMP: regs_q.oil_t32 <= cfg_data[13:0];
				REG_OIL_PRESSURE: regs_q.oil_kpa <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_MAX;
			slot_q <= SLOT_EEC1;
			sent_q <= 32'd0;
			cmd_speed_q <= 16'd0;
			cmd_seen_q <= 1'b0;
		end else if (advance) begin
			case (item_s1.func)
				FUNC_TICK: begin
					gap_q <= send ? 16'd0 : gap_inc;
					if (send) begin
						slot_q <= slot_next;
						sent_q <= sent_q + 32'd1;
					end
				end
				FUNC_RX: begin
					if (dec.hit) begin
						cmd_speed_q <= dec.speed;
						cmd_seen_q <= 1'b1;
					end
				end
				FUNC_CLEAR: begin
					slot_q <= SLOT_EEC1;
					sent_q <= 32'd0;
					cmd_speed_q <= 16'd0;
					cmd_seen_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			if (item_s1.func == FUNC_TICK) begin
				out_item_q.kind <= KIND_TX;
				out_item_q.tx_id <= enc_id;
				out_item_q.tx_payload <= enc_payload;
				out_item_q.cmd_speed_raw <= cmd_speed_q;
				out_item_q.cmd_valid <= cmd_seen_q;
				out_item_q.sent_total <= sent_q + 32'd1;
				out_item_q.next_slot <= slot_next;
			end else begin
				out_item_q.kind <= KIND_CMD;
				out_item_q.tx_id <= 29'd0;
				out_item_q.tx_payload <= 64'd0;
				out_item_q.cmd_speed_raw <= dec.speed;
				out_item_q.cmd_valid <= 1'b1;
				out_item_q.sent_total <= sent_q;
				out_item_q.next_slot <= slot_q;
			end
		end
	end

	a_slot_legal: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q != 2'd3)
		else $error("slot left the rotation");

	a_tx_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.kind == KIND_TX |->
		out_item_q.tx_id == ID_EEC1 || out_item_q.tx_id == ID_ET1
		|| out_item_q.tx_id == ID_EFLP1)
		else $error("transmitted frame with unknown identifier");

	a_cmd_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.kind == KIND_CMD |->
		out_item_q.cmd_valid && out_item_q.tx_id == 29'd0
		&& out_item_q.tx_payload == 64'd0)
		else $error("command item carries frame data");

	a_gap_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result && item_s1.func == FUNC_TICK |=> gap_q == 16'd0)
		else $error("gap counter not restarted after a frame");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_item_q))
		else $error("pending result overwritten");

endmodule

### bench/testbench.sv
// testbench for the engine frame scheduler: random stimulus with a predicting scoreboard
`timescale 1ns / 1ps

module testbench;
	import jefs_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 80;
	localparam int SETTLE_CYCLES = 4;

	class frame_scoreboard;
		localparam int TORQUE_OFFSET = 125;
		localparam int TEMP_OFFSET = 40;
		localparam int OIL_OFFSET = 8736;

		cfg_regs_t regs;
		logic [15:0] gap_ms;
		logic [1:0] slot;
		logic [31:0] sent;
		logic [15:0] cmd_speed;
		logic cmd_seen;
		out_item_t due_results[$];
		int errors;
		int tx_frames;

		function new();
			regs.sim_enable = 1'b0;
			regs.cycle_period_ms = 13'd500;
			regs.speed_rpm8 = 16'd12000;
			regs.torque_percent = 8'sd50;
			regs.clnt_degc = 9'sd85;
			regs.fuel_degc = 9'sd40;
			regs.oil_t32 = 14'sd2880;
			regs.oil_kpa = 10'd400;
			gap_ms = GAP_MAX;
			slot = SLOT_EEC1;
			sent = '0;
			cmd_speed = '0;
			cmd_seen = 1'b0;
			errors = 0;
			tx_frames = 0;
		endfunction

		function void write_reg(logic [3:0] idx, logic [15:0] data);
			case (idx)
				REG_SIM_ENABLE: regs.sim_enable = data[0];
				REG_CYCLE_PERIOD: regs.cycle_period_ms = data[12:0];
				REG_ENGINE_SPEED: regs.speed_rpm8 = data;
				REG_TORQUE: regs.torque_percent = data[7:0];
				REG_COOLANT: regs.clnt_degc = data[8:0];
				REG_FUEL: regs.fuel_degc = data[8:0];
				REG_OIL_TEMP: regs.oil_t32 = data[13:0];
				REG_OIL_PRESSURE: regs.oil_kpa = data[9:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] sat8(int v);
			if (v < 0)
				return '0;
			if (v > int'(RAW8_MAX))
				return RAW8_MAX;
			return 8'(v);
		endfunction

		function logic [15:0] sat16(int v);
			if (v < 0)
				return '0;
			if (v > int'(RAW16_MAX))
				return RAW16_MAX;
			return 16'(v);
		endfunction

		function void note_item(in_item_t it);
			out_item_t res;
			logic [15:0] hold_ms;
			logic [63:0] pay;
			logic [7:0] t;
			logic [15:0] std_raw;
			logic give;
			res = '0;
			give = 1'b0;
			case (it.func)
				FUNC_TICK: begin
					if (gap_ms != GAP_MAX)
						gap_ms++;
					if (!regs.sim_enable)
						return;
					if (slot == SLOT_EEC1 || slot == SLOT_ET1)
						hold_ms = 16'(GAP_WAIT);
					else if (regs.cycle_period_ms > GAP_SPENT)
						hold_ms = 16'(regs.cycle_period_ms - GAP_SPENT);
					else
						hold_ms = 16'(GAP_WAIT);
					if (gap_ms < hold_ms)
						return;
					gap_ms = '0;
					pay = '1;
					case (slot)
						SLOT_EEC1: begin
							t = sat8(int'($signed(regs.torque_percent)) + TORQUE_OFFSET);
							pay[15:8] = t;
							pay[23:16] = t;
							pay[39:24] = sat16(int'(regs.speed_rpm8));
							res.tx_id = ID_EEC1;
							slot = SLOT_ET1;
						end
						SLOT_ET1: begin
							pay[7:0] = sat8(int'($signed(regs.clnt_degc)) + TEMP_OFFSET);
							pay[15:8] = sat8(int'($signed(regs.fuel_degc)) + TEMP_OFFSET);
							pay[31:16] = sat16(int'($signed(regs.oil_t32)) + OIL_OFFSET);
							res.tx_id = ID_ET1;
							slot = SLOT_EFLP1;
						end
						default: begin
							pay[31:24] = sat8(int'(regs.oil_kpa >> 2));
							res.tx_id = ID_EFLP1;
							slot = SLOT_EEC1;
						end
					endcase
					sent++;
					tx_frames++;
					res.kind = KIND_TX;
					res.tx_payload = pay;
					give = 1'b1;
				end
				FUNC_RX: begin
					if (it.rx_id[23:16] == PF_TSC1) begin
						cmd_speed = it.rx_payload[23:8];
					end else if (it.rx_id[23:16] == PF_EEC1 && it.rx_id[15:8] == PS_EEC1
							&& it.rx_id[7:0] != '0) begin
						std_raw = it.rx_payload[39:24];
						cmd_speed = (std_raw != RAW16_NA) ? std_raw : it.rx_payload[47:32];
					end else begin
						return;
					end
					cmd_seen = 1'b1;
					res.kind = KIND_CMD;
					give = 1'b1;
				end
				FUNC_CLEAR: begin
					sent = '0;
					slot = SLOT_EEC1;
					cmd_seen = 1'b0;
					cmd_speed = '0;
				end
				default: ;
			endcase
			if (give) begin
				res.cmd_speed_raw = cmd_speed;
				res.cmd_valid = cmd_seen;
				res.sent_total = sent;
				res.next_slot = slot;
				due_results.push_back(res);
			end
		endfunction

		function void diff(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s expected %h actual %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				$error("result with none expected: %h", got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			diff("kind", 64'(want.kind), 64'(got.kind));
			diff("tx_id", 64'(want.tx_id), 64'(got.tx_id));
			diff("tx_payload", want.tx_payload, got.tx_payload);
			diff("cmd_speed_raw", 64'(want.cmd_speed_raw), 64'(got.cmd_speed_raw));
			diff("cmd_valid", 64'(want.cmd_valid), 64'(got.cmd_valid));
			diff("sent_total", 64'(want.sent_total), 64'(got.sent_total));
			diff("next_slot", 64'(want.next_slot), 64'(got.next_slot));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_index;
	logic [15:0] cfg_data;
	logic no_idle;
	int idle_cycles = 0;

	frame_scoreboard sb = new();

	j1939_engine_frame_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t mk(logic [1:0] f, logic [28:0] id, logic [63:0] pay);
		in_item_t it;
		it.func = f;
		it.rx_id = id;
		it.rx_payload = pay;
		return it;
	endfunction

	// mostly well-formed speed commands, some near misses
	function automatic in_item_t rx_frame();
		in_item_t it;
		int r;
		r = $urandom_range(0, 9);
		it = mk(FUNC_RX, 29'($urandom), {$urandom, $urandom});
		if (r < 4) begin
			it.rx_id[23:16] = PF_TSC1;
		end else begin
			it.rx_id[23:16] = PF_EEC1;
			if (r != 9)
				it.rx_id[15:8] = PS_EEC1;
			if (r == 8)
				it.rx_id[7:0] = '0;
			if (r < 6)
				it.rx_payload[39:24] = RAW16_NA;
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic set_all(input bit en, input int period, input int speed, input int torque,
			input int cool, input int fuel, input int oil, input int press);
		cfg_write(REG_SIM_ENABLE, 16'(en));
		cfg_write(REG_CYCLE_PERIOD, 16'(period));
		cfg_write(REG_ENGINE_SPEED, 16'(speed));
		cfg_write(REG_TORQUE, 16'(torque));
		cfg_write(REG_COOLANT, 16'(cool));
		cfg_write(REG_FUEL, 16'(fuel));
		cfg_write(REG_OIL_TEMP, 16'(oil));
		cfg_write(REG_OIL_PRESSURE, 16'(press));
		// unused index must leave everything alone
		cfg_write(4'($urandom_range(REG_OIL_PRESSURE + 1, 15)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int goal, input bit want_frames);
		int n;
		int frames0;
		int r;
		int burst;
		n = 0;
		frames0 = sb.tx_frames;
		while (n < goal || (want_frames && sb.tx_frames < frames0 + 3)) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				burst = $urandom_range(1, 25);
				repeat (burst)
					send_item(mk(FUNC_TICK, 29'($urandom), {$urandom, $urandom}));
				n += burst;
			end else if (r < 80) begin
				send_item(rx_frame());
				n++;
			end else if (r < 86) begin
				send_item(mk(FUNC_CLEAR, 29'($urandom), {$urandom, $urandom}));
				n++;
			end else if (r < 92) begin
				send_item(mk('1, 29'($urandom), {$urandom, $urandom}));
			end else begin
				send_item(mk(FUNC_RX, 29'($urandom), {$urandom, $urandom}));
			end
			if ($urandom_range(0, 39) == 0)
				drain();
		end
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);

	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 2) == 0)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		no_idle = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// disabled ticks with the gap counter held at its maximum
		send_item(mk(FUNC_TICK, '0, '0));
		send_item(mk(FUNC_TICK, '1, '1));
		send_item(mk(FUNC_RX, 29'h0C00_0003, '1));
		send_item(mk(FUNC_RX, 29'h1F00_FFFF, '0));
		// speed bytes not available, fallback pair
		send_item(mk(FUNC_RX, ID_EEC1 + 29'd3, 64'h0000_12FF_FF00_0000));
		send_item(mk(FUNC_RX, ID_EEC1 | 29'hFF, {$urandom, $urandom}));
		send_item(mk(FUNC_RX, ID_EEC1, '1));
		send_item(mk(FUNC_RX, ID_ET1, '1));
		send_item(mk(FUNC_RX, ID_EEC1 + 29'h100, '1));
		send_item(mk('1, '1, '1));
		send_item(mk(FUNC_CLEAR, '0, '0));
		send_item(mk(FUNC_RX, 29'h0C00_0003, {$urandom, $urandom}));
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_all(1, 150, 64000, 125, 210, 210, 4800, 1000);
				1: set_all(1, 5000, 0, -125, -40, -40, -1280, 0);
				2: set_all(1, 100, 65535, 127, 255, 255, 8191, 1023);
				3: set_all(1, 101, 0, -128, -256, -256, -8192, 0);
				4: set_all(0, $urandom_range(150, 400), $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom);
				5: set_all(1, $urandom_range(0, 99), $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom);
				default: set_all(1, $urandom_range(150, 400), $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom);
			endcase
			no_idle = (p == 2 || p == 5);
			// first enabled tick goes out at once
			if (p == 0)
				send_item(mk(FUNC_TICK, '0, '1));
			// long cycle or disabled: the oil pressure frame stays held back
			random_phase(PHASE_ITEMS, p != 4 && p != 1);
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
src/jefs_pkg.sv
src/jefs_encode.sv
src/jefs_rxdec.sv
src/j1939_engine_frame_scheduler.sv
bench/testbench.sv
